>>> sv/mks_pkg.sv
// ----------------------------------------------------------------------------
// mks_pkg
// Shared types, constants and the key lookup for the keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

    localparam int ROW_W   = 4;
    localparam int COL_W   = 3;
    localparam int CODE_W  = 4;
    localparam int TICK_W  = 10;
    localparam int SETTLE_W = 8;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_ADDR_W = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BEEP_ON    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BEEP_OFF   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE    = 2'd3;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET  = 8'd10;
    localparam logic [TICK_W-1:0]   BEEP_ON_RESET  = 10'd50;
    localparam logic [TICK_W-1:0]   BEEP_OFF_RESET = 10'd50;
    localparam logic [TICK_W-1:0]   RELEASE_RESET  = 10'd50;

    localparam logic [1:0] LAST_COLUMN = 2'd2;

    typedef enum logic [2:0] {
        PH_SETTLE   = 3'd0,
        PH_BEEP_ON  = 3'd1,
        PH_BEEP_OFF = 3'd2,
        PH_POLL     = 3'd3
    } phase_t;

    typedef struct packed {
        logic [SETTLE_W-1:0] settle_ticks;
        logic [TICK_W-1:0]   beep_on_ticks;
        logic [TICK_W-1:0]   beep_off_ticks;
        logic [TICK_W-1:0]   release_poll_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic [1:0]          column_index;
        logic [TICK_W-1:0]   tick_count;
        logic [1:0]          held_row;
        logic [CODE_W-1:0]   held_code;
    } scan_state_t;

    typedef struct packed {
        logic              pass_empty;
        logic [CODE_W-1:0] key_code;
        logic              key_ready;
        logic              buzzer_on;
        logic [COL_W-1:0]  column_drive;
    } result_t;

    function automatic logic [CODE_W-1:0] key_lookup(input logic [1:0] col,
                                                     input logic [1:0] row);
        logic [CODE_W-1:0] code;
        case ({col, row})
            4'b00_00: code = 4'd1;
            4'b00_01: code = 4'd4;
            4'b00_10: code = 4'd7;
            4'b00_11: code = 4'd10;
            4'b01_00: code = 4'd2;
            4'b01_01: code = 4'd5;
            4'b01_10: code = 4'd8;
            4'b01_11: code = 4'd0;
            4'b10_00: code = 4'd3;
            4'b10_01: code = 4'd6;
            4'b10_10: code = 4'd9;
            4'b10_11: code = 4'd11;
            default:  code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

>>> sv/mks_cfg_regs.sv
// ----------------------------------------------------------------------------
// mks_cfg_regs
// Timing registers of the keypad scanner, written through a plain write port.
// ----------------------------------------------------------------------------
module mks_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mks_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mks_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output mks_pkg::cfg_t                     cfg
);

    mks_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ticks       <= mks_pkg::SETTLE_RESET;
            cfg_reg.beep_on_ticks      <= mks_pkg::BEEP_ON_RESET;
            cfg_reg.beep_off_ticks     <= mks_pkg::BEEP_OFF_RESET;
            cfg_reg.release_poll_ticks <= mks_pkg::RELEASE_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                mks_pkg::REG_SETTLE: begin
                    cfg_reg.settle_ticks <= cfg_wdata[mks_pkg::SETTLE_W-1:0];
                end
                mks_pkg::REG_BEEP_ON: begin
                    cfg_reg.beep_on_ticks <= cfg_wdata[mks_pkg::TICK_W-1:0];
                end
                mks_pkg::REG_BEEP_OFF: begin
                    cfg_reg.beep_off_ticks <= cfg_wdata[mks_pkg::TICK_W-1:0];
                end
                mks_pkg::REG_RELEASE: begin
                    cfg_reg.release_poll_ticks <= cfg_wdata[mks_pkg::TICK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/mks_step.sv
// ----------------------------------------------------------------------------
// mks_step
// One tick of the scan sequence: next state and the result of the tick.
// ----------------------------------------------------------------------------
module mks_step (
    input  mks_pkg::cfg_t                 cfg,
    input  mks_pkg::scan_state_t          state,
    input  logic [mks_pkg::ROW_W-1:0]     row_levels,
    output mks_pkg::scan_state_t          state_next,
    output mks_pkg::result_t              result
);

    logic [1:0]                   col;
    logic [mks_pkg::TICK_W-1:0]   tick_inc;
    logic [mks_pkg::TICK_W:0]     settle_sum;
    logic [mks_pkg::SETTLE_W-1:0] settle_min;
    logic [mks_pkg::TICK_W-1:0]   on_min;
    logic [mks_pkg::TICK_W-1:0]   off_min;
    logic [mks_pkg::TICK_W-1:0]   poll_min;
    logic                         found;
    logic [1:0]                   found_row;

    assign col        = (state.column_index > mks_pkg::LAST_COLUMN) ?
                        mks_pkg::LAST_COLUMN : state.column_index;
    assign tick_inc   = state.tick_count + mks_pkg::TICK_W'(1);
    assign settle_sum = {1'b0, state.tick_count} + (mks_pkg::TICK_W+1)'(1);
    assign settle_min = (cfg.settle_ticks == '0) ? mks_pkg::SETTLE_W'(1)
                                                 : cfg.settle_ticks;
    assign on_min     = (cfg.beep_on_ticks == '0) ? mks_pkg::TICK_W'(1)
                                                  : cfg.beep_on_ticks;
    assign off_min    = (cfg.beep_off_ticks == '0) ? mks_pkg::TICK_W'(1)
                                                   : cfg.beep_off_ticks;
    assign poll_min   = (cfg.release_poll_ticks == '0) ? mks_pkg::TICK_W'(1)
                                                       : cfg.release_poll_ticks;

    always_comb begin
        found     = 1'b0;
        found_row = 2'd0;
        for (int r = 0; r < mks_pkg::ROW_W; r++) begin
            if (!row_levels[r]) begin
                found     = 1'b1;
                found_row = 2'(r);
            end
        end
    end

    always_comb begin
        state_next          = state;
        result.column_drive = ~(mks_pkg::COL_W'(1) << col);
        result.buzzer_on    = 1'b0;
        result.key_ready    = 1'b0;
        result.key_code     = '0;
        result.pass_empty   = 1'b0;

        case (state.phase)
            mks_pkg::PH_BEEP_ON: begin
                result.buzzer_on      = 1'b1;
                state_next.tick_count = tick_inc;
                if (tick_inc >= on_min) begin
                    state_next.phase      = mks_pkg::PH_BEEP_OFF;
                    state_next.tick_count = '0;
                end
            end
            mks_pkg::PH_BEEP_OFF: begin
                state_next.tick_count = tick_inc;
                if (tick_inc >= off_min) begin
                    state_next.phase      = mks_pkg::PH_POLL;
                    state_next.tick_count = '0;
                end
            end
            mks_pkg::PH_POLL: begin
                if (state.tick_count == '0 && row_levels[state.held_row]) begin
                    result.key_ready        = 1'b1;
                    result.key_code         = state.held_code;
                    state_next.phase        = mks_pkg::PH_SETTLE;
                    state_next.column_index = '0;
                    state_next.tick_count   = '0;
                end else if (tick_inc >= poll_min) begin
                    state_next.tick_count = '0;
                end else begin
                    state_next.tick_count = tick_inc;
                end
            end
            default: begin
                if (settle_sum < {3'b000, settle_min}) begin
                    state_next.tick_count = tick_inc;
                end else begin
                    state_next.tick_count = '0;
                    state_next.phase      = mks_pkg::PH_SETTLE;
                    if (found) begin
                        state_next.held_row  = found_row;
                        state_next.held_code = mks_pkg::key_lookup(col, found_row);
                        state_next.phase     = mks_pkg::PH_BEEP_ON;
                    end else if (col == mks_pkg::LAST_COLUMN) begin
                        result.pass_empty       = 1'b1;
                        state_next.column_index = '0;
                    end else begin
                        state_next.column_index = col + 2'd1;
                    end
                end
            end
        endcase
    end

endmodule

>>> sv/matrix_keypad_scanner_top.sv
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_top
// Tick-driven 4x3 matrix keypad scanner with key beep and release reporting.
// ----------------------------------------------------------------------------
// Each input transaction on the s_axis channel is one time tick carrying the
// sampled row levels. Each tick yields exactly one output transaction on the
// m_axis channel with the column drive, buzzer, key and empty-pass flags.
// The tick passes an input register, then the scan step logic, then the
// output register.
// One transaction is accepted per cycle unless the receiver stalls; the rate
// is set by the single step-logic pass that updates the scan state each tick.
// When the receiver stalls, the output register holds its transaction and
// the input register takes one more tick; s_axis_tready then drops until
// the output is taken. The scan state only advances when a tick moves into
// the output register. Reset clears both valid flags, puts the scanner in the
// settle phase at column 0 and loads the default timing registers.
// Timing registers are written through cfg_we, cfg_addr and cfg_wdata, by
// the user only while no tick is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] row_levels
    input  logic [mks_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] column_drive, [3] buzzer_on, [4] key_ready, [8:5] key_code,
    // [9] pass_empty
    output logic [mks_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [mks_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mks_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    mks_pkg::cfg_t                cfg;
    mks_pkg::scan_state_t         state_reg;
    mks_pkg::scan_state_t         state_next;
    mks_pkg::result_t             result_next;
    mks_pkg::result_t             result_reg;
    logic                         in_valid_reg;
    logic [mks_pkg::ROW_W-1:0]    rows_reg;
    logic                         out_valid_reg;
    logic                         load_out;

    mks_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mks_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .row_levels (rows_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign load_out      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || load_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_valid_reg <= 1'b1;
        end else if (load_out) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            rows_reg <= s_axis_tdata[mks_pkg::ROW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg          <= 1'b0;
            state_reg.phase        <= mks_pkg::PH_SETTLE;
            state_reg.column_index <= '0;
            state_reg.tick_count   <= '0;
            state_reg.held_row     <= '0;
            state_reg.held_code    <= '0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
            state_reg     <= state_next;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(mks_pkg::M_TDATA_W - $bits(mks_pkg::result_t))'(0), result_reg};

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(result_reg.key_ready && result_reg.pass_empty))
        else $error("key_ready and pass_empty set in the same transaction");

    a_column_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.column_index != 2'd3)
        else $error("column index left the valid range");

    a_release_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && result_next.key_ready) |=>
            (state_reg.phase == mks_pkg::PH_SETTLE && state_reg.column_index == 2'd0))
        else $error("key release did not restart the scan at column 0");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !load_out |=> $stable(state_reg))
        else $error("scan state changed without a tick");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the 4x3 matrix keypad scanner.
// ----------------------------------------------------------------------------
// Row samples go in one tick per transaction. A scan model inside the
// testbench predicts every output transaction, and each result is compared
// field by field in order of arrival. The run starts with a directed press
// sequence with the timing registers at zero. Random press episodes with
// chatter, short presses and noise follow under several timing settings.
// One sequence uses the largest settle and poll values. Both channels idle
// at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [3:0] ROWS_IDLE = 4'hF;
    // Key codes indexed by column * 4 + row.
    localparam logic [11:0][3:0] KEYMAP = {
        4'd11, 4'd9, 4'd6, 4'd3,
        4'd0,  4'd8, 4'd5, 4'd2,
        4'd10, 4'd7, 4'd4, 4'd1
    };

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [mks_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [mks_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                            cfg_we        = 1'b0;
    logic [mks_pkg::CFG_ADDR_W-1:0]  cfg_addr      = '0;
    logic [mks_pkg::CFG_DATA_W-1:0]  cfg_wdata     = '0;

    logic [3:0]       tick_q[$];
    mks_pkg::result_t expected_results[$];

    mks_pkg::cfg_t    sc_cfg;
    mks_pkg::phase_t  sc_phase;
    logic [1:0]       sc_col;
    logic [9:0]       sc_ticks;
    logic [1:0]       sc_row;
    logic [3:0]       sc_code;

    int send_gap   = 0;
    int send_calm  = 0;
    int recv_stall = 0;
    int recv_calm  = 0;
    int mismatches = 0;
    int results_checked = 0;
    int keys_seen = 0;
    int empties_seen = 0;
    int settings_run = 0;

    matrix_keypad_scanner_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    function automatic int min_one(input logic [9:0] v);
        return (v == 10'd0) ? 1 : int'(v);
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    function automatic mks_pkg::result_t scan_tick(input logic [3:0] rows);
        mks_pkg::result_t res;
        logic [1:0]       col;
        int               hit;
        res = '0;
        col = (sc_col > mks_pkg::LAST_COLUMN) ? mks_pkg::LAST_COLUMN : sc_col;
        res.column_drive = 3'b111 & ~(3'b001 << col);
        case (sc_phase)
            mks_pkg::PH_BEEP_ON: begin
                res.buzzer_on = 1'b1;
                sc_ticks = sc_ticks + 10'd1;
                if (int'(sc_ticks) >= min_one(sc_cfg.beep_on_ticks)) begin
                    sc_phase = mks_pkg::PH_BEEP_OFF;
                    sc_ticks = '0;
                end
            end
            mks_pkg::PH_BEEP_OFF: begin
                sc_ticks = sc_ticks + 10'd1;
                if (int'(sc_ticks) >= min_one(sc_cfg.beep_off_ticks)) begin
                    sc_phase = mks_pkg::PH_POLL;
                    sc_ticks = '0;
                end
            end
            mks_pkg::PH_POLL: begin
                if (sc_ticks == 10'd0 && rows[sc_row]) begin
                    res.key_ready = 1'b1;
                    res.key_code  = sc_code;
                    sc_phase = mks_pkg::PH_SETTLE;
                    sc_col   = '0;
                end else begin
                    sc_ticks = sc_ticks + 10'd1;
                    if (int'(sc_ticks) >= min_one(sc_cfg.release_poll_ticks)) begin
                        sc_ticks = '0;
                    end
                end
            end
            default: begin
                if (int'(sc_ticks) + 1 < min_one(10'(sc_cfg.settle_ticks))) begin
                    sc_ticks = sc_ticks + 10'd1;
                end else begin
                    sc_ticks = '0;
                    hit = -1;
                    for (int r = 3; r >= 0; r--) begin
                        if (hit < 0 && !rows[r]) hit = r;
                    end
                    if (hit >= 0) begin
                        sc_row   = 2'(hit);
                        sc_code  = KEYMAP[int'(col) * 4 + hit];
                        sc_phase = mks_pkg::PH_BEEP_ON;
                    end else if (col == mks_pkg::LAST_COLUMN) begin
                        res.pass_empty = 1'b1;
                        sc_col   = '0;
                        sc_phase = mks_pkg::PH_SETTLE;
                    end else begin
                        sc_col   = col + 2'd1;
                        sc_phase = mks_pkg::PH_SETTLE;
                    end
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin : tick_driver
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(scan_tick(s_axis_tdata[3:0]));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (tick_q.size() > 0) begin
                    s_axis_tdata  <= {4'b0000, tick_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    send_gap      <= draw_wait(send_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        mks_pkg::result_t got;
        mks_pkg::result_t want;
        int               stall;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            got = mks_pkg::result_t'(m_axis_tdata[9:0]);
            results_checked++;
            if (got.key_ready === 1'b1) keys_seen++;
            if (got.pass_empty === 1'b1) empties_seen++;
            if (expected_results.size() == 0) begin
                if (mismatches < 10) begin
                    $display("%0t: unexpected transaction, tdata %h", $realtime,
                             m_axis_tdata);
                end
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got.column_drive !== want.column_drive
                        || got.buzzer_on !== want.buzzer_on
                        || got.key_ready !== want.key_ready
                        || got.key_code !== want.key_code
                        || got.pass_empty !== want.pass_empty) begin
                    if (mismatches < 10) begin
                        $display({"%0t: mismatch col/buzz/ready/code/empty",
                                  " exp %b %b %b %0d %b got %b %b %b %0d %b"},
                                 $realtime, want.column_drive, want.buzzer_on,
                                 want.key_ready, want.key_code, want.pass_empty,
                                 got.column_drive, got.buzzer_on, got.key_ready,
                                 got.key_code, got.pass_empty);
                    end
                    mismatches++;
                end
            end
            stall = draw_wait(recv_calm);
            recv_stall    <= stall;
            m_axis_tready <= (stall == 0);
        end else if (recv_stall > 0) begin
            recv_stall    <= recv_stall - 1;
            m_axis_tready <= (recv_stall == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic wait_idle();
        while (tick_q.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [mks_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [mks_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            mks_pkg::REG_SETTLE:   sc_cfg.settle_ticks       = val[mks_pkg::SETTLE_W-1:0];
            mks_pkg::REG_BEEP_ON:  sc_cfg.beep_on_ticks      = val;
            mks_pkg::REG_BEEP_OFF: sc_cfg.beep_off_ticks     = val;
            mks_pkg::REG_RELEASE:  sc_cfg.release_poll_ticks = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_timing(input int settle, input int on, input int off, input int poll);
        wait_idle();
        write_reg(mks_pkg::REG_SETTLE, mks_pkg::CFG_DATA_W'(settle));
        write_reg(mks_pkg::REG_BEEP_ON, mks_pkg::CFG_DATA_W'(on));
        write_reg(mks_pkg::REG_BEEP_OFF, mks_pkg::CFG_DATA_W'(off));
        write_reg(mks_pkg::REG_RELEASE, mks_pkg::CFG_DATA_W'(poll));
        settings_run++;
    endtask

    task automatic queue_ticks(input logic [3:0] rows, input int n);
        repeat (n) tick_q.push_back(rows);
    endtask

    task automatic queue_presses(input int n_items);
        int         span;
        int         hold;
        int         r;
        bit         chatter;
        logic [3:0] pat;
        span = 3 * min_one(10'(sc_cfg.settle_ticks)) + min_one(sc_cfg.beep_on_ticks)
             + min_one(sc_cfg.beep_off_ticks);
        while (tick_q.size() < n_items) begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 8)) tick_q.push_back(4'($urandom_range(0, 15)));
                1: queue_ticks(4'($urandom_range(0, 14)),
                               $urandom_range(1, min_one(10'(sc_cfg.settle_ticks))));
                default: begin
                    queue_ticks(ROWS_IDLE, $urandom_range(0, span));
                    r = $urandom_range(0, 3);
                    pat = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                      : ~(4'b0001 << r);
                    pat[r] = 1'b0;
                    chatter = ($urandom_range(0, 3) == 0);
                    hold = $urandom_range(1, span + 3 * min_one(sc_cfg.release_poll_ticks) + 4);
                    for (int k = 0; k < hold; k++) begin
                        tick_q.push_back(chatter ? (4'($urandom_range(0, 15)) & ~(4'b0001 << r))
                                                 : pat);
                    end
                end
            endcase
        end
    endtask

    initial begin
        sc_cfg   = '{mks_pkg::SETTLE_RESET, mks_pkg::BEEP_ON_RESET, mks_pkg::BEEP_OFF_RESET,
                     mks_pkg::RELEASE_RESET};
        sc_phase = mks_pkg::PH_SETTLE;
        sc_col   = '0;
        sc_ticks = '0;
        sc_row   = '0;
        sc_code  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero timing values behave as one, so every tick samples a column.
        set_timing(0, 0, 0, 0);
        @(negedge aclk);
        tick_q = '{4'hF, 4'hF, 4'hF, 4'h7, 4'h0, 4'h0, 4'h0, 4'h7, 4'h8, 4'hE, 4'hF, 4'hF,
                   4'hF, 4'hF, 4'hB, 4'h0, 4'h0, 4'h4, 4'hF, 4'hF, 4'h0, 4'h5, 4'h5, 4'hF,
                   4'hF, 4'h6, 4'hF, 4'hF, 4'hF};

        set_timing(1, 1, 1, 1);
        @(negedge aclk);
        queue_presses(100);
        set_timing(3, 5, 4, 2);
        @(negedge aclk);
        queue_presses(130);
        repeat (3) begin
            set_timing($urandom_range(1, 6), $urandom_range(1, 12), $urandom_range(1, 12),
                       $urandom_range(1, 8));
            @(negedge aclk);
            queue_presses(80);
        end

        // Largest settle and poll values; the key is let go before the first release check.
        set_timing(255, 2, 2, 1023);
        @(negedge aclk);
        queue_ticks(4'hD, 255 + 2 + 2);
        queue_ticks(ROWS_IDLE, 8);

        set_timing(10, 50, 50, 50);
        @(negedge aclk);
        queue_ticks(ROWS_IDLE, 3 * 10);
        wait_idle();
        repeat (8) @(posedge aclk);

        $display("tb_top: %0d ticks checked under %0d timing settings", results_checked,
                 settings_run);
        $display("tb_top: %0d key reports, %0d empty passes, %0d mismatches", keys_seen,
                 empties_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> sim.f
sv/mks_pkg.sv
sv/mks_cfg_regs.sv
sv/mks_step.sv
sv/matrix_keypad_scanner_top.sv
tb/tb_top.sv
